// ===== rtl/mdvp_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the vertex peeling block.
package mdvp_pkg;

    // Store sizes and derived widths.
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = 11;
    localparam int FW = EW + 1;
    localparam int IW = (FW > VW + 1) ? FW : VW + 1;
    localparam logic [CW-1:0] CNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CLIQUE  = 2'd0;
    localparam logic [1:0] CFG_PLEX_K  = 2'd1;
    localparam logic [1:0] CFG_MAXPASS = 2'd2;
    localparam logic [1:0] CFG_VTOTAL  = 2'd3;

    typedef enum logic [2:0] {
        OP_SET_VTX   = 3'd0,
        OP_ADD_EDGE  = 3'd1,
        OP_RUN       = 3'd2,
        OP_RD_VTX    = 3'd3,
        OP_RD_EDGE   = 3'd4,
        OP_CLR_EDGES = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_CNT_CLR,
        S_E0, S_E1, S_E2, S_E3,
        S_V0, S_V1,
        S_M0, S_M1, S_M2,
        S_PASS_END, S_PASS_CHK, S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic idx_zero;
        logic idx_inc;
        logic clr_wr;
        logic cnt_clr;
        logic edge_rd;
        logic nb_rd;
        logic bump_a;
        logic bump_b;
        logic vtx_rd;
        logic vtx_dec;
        logic mark_rd;
        logic mark_wr;
        logic run_start;
        logic pass_start;
        logic pass_end;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_lt_nv;
        logic idx_lt_fill;
        logic idx_last_v;
        logic more_passes;
        logic op_run;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/mdvp_ctrl.sv =====
// Controller state machine that sequences item execution and the peeling passes.
module mdvp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mdvp_pkg::t_dp_stat i_stat,
    output mdvp_pkg::t_dp_cmd  o_cmd
);

    mdvp_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdvp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            mdvp_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.idx_last_v) begin
                    o_cmd.idx_zero = 1'b1;
                    n_state = mdvp_pkg::S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            mdvp_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = mdvp_pkg::S_EXEC;
                end
            end
            mdvp_pkg::S_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.idx_zero = 1'b1;
                if (i_stat.op_run) begin
                    o_cmd.run_start = 1'b1;
                    n_state = mdvp_pkg::S_CNT_CLR;
                end else begin
                    n_state = mdvp_pkg::S_FINISH;
                end
            end
            mdvp_pkg::S_CNT_CLR: begin
                if (i_stat.idx_lt_nv) begin
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    o_cmd.idx_zero = 1'b1;
                    n_state = mdvp_pkg::S_E0;
                end
            end
            mdvp_pkg::S_E0: begin
                if (i_stat.idx_lt_fill) begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = mdvp_pkg::S_E1;
                end else begin
                    o_cmd.idx_zero = 1'b1;
                    n_state = mdvp_pkg::S_V0;
                end
            end
            mdvp_pkg::S_E1: begin
                o_cmd.nb_rd = 1'b1;
                n_state = mdvp_pkg::S_E2;
            end
            mdvp_pkg::S_E2: begin
                o_cmd.bump_a = 1'b1;
                n_state = mdvp_pkg::S_E3;
            end
            mdvp_pkg::S_E3: begin
                o_cmd.bump_b  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = mdvp_pkg::S_E0;
            end
            mdvp_pkg::S_V0: begin
                if (i_stat.idx_lt_nv) begin
                    o_cmd.vtx_rd = 1'b1;
                    n_state = mdvp_pkg::S_V1;
                end else begin
                    o_cmd.idx_zero = 1'b1;
                    n_state = mdvp_pkg::S_M0;
                end
            end
            mdvp_pkg::S_V1: begin
                o_cmd.vtx_dec = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = mdvp_pkg::S_V0;
            end
            mdvp_pkg::S_M0: begin
                if (i_stat.idx_lt_fill) begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = mdvp_pkg::S_M1;
                end else begin
                    n_state = mdvp_pkg::S_PASS_END;
                end
            end
            mdvp_pkg::S_M1: begin
                o_cmd.mark_rd = 1'b1;
                n_state = mdvp_pkg::S_M2;
            end
            mdvp_pkg::S_M2: begin
                o_cmd.mark_wr = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = mdvp_pkg::S_M0;
            end
            mdvp_pkg::S_PASS_END: begin
                o_cmd.pass_end = 1'b1;
                n_state = mdvp_pkg::S_PASS_CHK;
            end
            mdvp_pkg::S_PASS_CHK: begin
                if (i_stat.more_passes) begin
                    o_cmd.pass_start = 1'b1;
                    o_cmd.idx_zero   = 1'b1;
                    n_state = mdvp_pkg::S_CNT_CLR;
                end else begin
                    n_state = mdvp_pkg::S_FINISH;
                end
            end
            mdvp_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = mdvp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mdvp_pkg::S_IDLE;
            end
        endcase
    end

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded into an occupied output register");

    // No transfer is taken while the reset clearing sweep runs.
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdvp_pkg::S_CLEAR) |-> !o_ready)
        else $error("input taken during clearing sweep");

    // A run always leaves the pass check through a fresh pass or the result.
    a_pass_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdvp_pkg::S_PASS_CHK) |=>
            (r_state == mdvp_pkg::S_CNT_CLR || r_state == mdvp_pkg::S_FINISH))
        else $error("bad exit from pass check");

endmodule

// ===== rtl/mdvp_dp.sv =====
// Datapath with the vertex, count, edge stores, run counters and the output register.
module mdvp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [2:0]         i_operation,
    input  logic [9:0]         i_vertex_index,
    input  logic [9:0]         i_neighbor_index,
    input  logic [12:0]        i_edge_index,
    input  logic               i_alive_in,
    input  logic               i_ready,
    input  mdvp_pkg::t_dp_cmd  i_cmd,
    output mdvp_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic               o_alive_out,
    output logic               o_last_pass_reduced,
    output logic [15:0]        o_passes_used,
    output logic [10:0]        o_removed_total,
    output logic [13:0]        o_edge_total
);

    localparam int VW = mdvp_pkg::VW;
    localparam int EW = mdvp_pkg::EW;
    localparam int CW = mdvp_pkg::CW;
    localparam int FW = mdvp_pkg::FW;
    localparam int IW = mdvp_pkg::IW;

    // Configuration registers.
    logic [10:0] r_clique, r_plexk, r_vt;
    logic [15:0] r_maxp;

    // Latched item.
    logic [2:0]  r_op;
    logic [9:0]  r_vi, r_ni;
    logic [12:0] r_ei;
    logic        r_al;

    // Control and run registers.
    logic [FW-1:0] r_fill;
    logic [IW-1:0] r_idx;
    logic [15:0]   r_passes;
    logic [10:0]   r_removed;
    logic          r_reduced;
    logic [1:0]    r_status;
    logic          r_ovalid;

    // Registered memory read data.
    logic [VW-1:0] r_ea, r_eb;
    logic          r_al_a, r_al_b, r_rm_a, r_rm_b, r_rde;
    logic [CW-1:0] r_cnt_a, r_cnt_b;

    // Stores.
    logic          m_alive  [mdvp_pkg::MAX_VERTICES];
    logic          m_rmn    [mdvp_pkg::MAX_VERTICES];
    logic [CW-1:0] m_cnt    [mdvp_pkg::MAX_VERTICES];
    logic [VW-1:0] m_ep_a   [mdvp_pkg::MAX_EDGES];
    logic [VW-1:0] m_ep_b   [mdvp_pkg::MAX_EDGES];
    logic          m_ealive [mdvp_pkg::MAX_EDGES];

    logic [CW-1:0] nv, thr;
    logic [VW-1:0] idx_v, vi_a, ni_a;
    logic [EW-1:0] idx_e, fill_a, ei_a;
    logic          vi_bad, ni_bad, ei_bad, full, in_range, do_a, do_b, rm, add_ok, set_ok;
    logic [1:0]    exec_status;
    logic          al_we, al_wd, cnt_we;
    logic [VW-1:0] al_wa, al_ra, cnt_wa, cnt_ra;
    logic [CW-1:0] cnt_wd;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clique <= '0;
            r_plexk  <= 11'd1;
            r_maxp   <= '1;
            r_vt     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mdvp_pkg::CFG_CLIQUE:  r_clique <= i_cfg_data[10:0];
                mdvp_pkg::CFG_PLEX_K:  r_plexk  <= i_cfg_data[10:0];
                mdvp_pkg::CFG_MAXPASS: r_maxp   <= i_cfg_data;
                mdvp_pkg::CFG_VTOTAL:  r_vt     <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Item capture on an input transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_operation;
            r_vi <= i_vertex_index;
            r_ni <= i_neighbor_index;
            r_ei <= i_edge_index;
            r_al <= i_alive_in;
        end
    end

    // Derived run limits and addresses.
    assign nv     = (r_vt > CW'(mdvp_pkg::MAX_VERTICES)) ? CW'(mdvp_pkg::MAX_VERTICES) : r_vt;
    assign thr    = (r_clique > r_plexk) ? r_clique - r_plexk : '0;
    assign idx_v  = r_idx[VW-1:0];
    assign idx_e  = r_idx[EW-1:0];
    assign vi_a   = VW'(r_vi);
    assign ni_a   = VW'(r_ni);
    assign ei_a   = EW'(r_ei);
    assign fill_a = r_fill[EW-1:0];

    // Item checks.
    assign vi_bad = 32'(r_vi) >= 32'(mdvp_pkg::MAX_VERTICES);
    assign ni_bad = 32'(r_ni) >= 32'(mdvp_pkg::MAX_VERTICES);
    assign ei_bad = FW'(r_ei) >= r_fill;
    assign full   = r_fill >= FW'(mdvp_pkg::MAX_EDGES);
    assign set_ok = (r_op == mdvp_pkg::OP_SET_VTX) && !vi_bad;
    assign add_ok = (r_op == mdvp_pkg::OP_ADD_EDGE) && !vi_bad && !ni_bad && !full;

    always_comb begin
        case (r_op) inside
            mdvp_pkg::OP_SET_VTX, mdvp_pkg::OP_RD_VTX:
                exec_status = vi_bad ? mdvp_pkg::ST_RANGE : mdvp_pkg::ST_OK;
            mdvp_pkg::OP_ADD_EDGE:
                exec_status = (vi_bad || ni_bad) ? mdvp_pkg::ST_RANGE :
                              full ? mdvp_pkg::ST_FULL : mdvp_pkg::ST_OK;
            mdvp_pkg::OP_RD_EDGE:
                exec_status = ei_bad ? mdvp_pkg::ST_RANGE : mdvp_pkg::ST_OK;
            default:
                exec_status = mdvp_pkg::ST_OK;
        endcase
    end

    // Edge decisions of the counting and marking walks.
    assign in_range = (CW'(r_ea) < nv) && (CW'(r_eb) < nv);
    assign do_a     = in_range && r_al_b && (r_cnt_a != mdvp_pkg::CNT_MAX);
    assign do_b     = in_range && (r_ea != r_eb) && r_al_a && (r_cnt_b != mdvp_pkg::CNT_MAX);
    assign rm       = r_al_a && (r_cnt_a < thr);

    // Alive store port selection.
    always_comb begin
        al_we = 1'b0;
        al_wa = idx_v;
        al_wd = 1'b0;
        if (i_cmd.clr_wr) begin
            al_we = 1'b1;
        end else if (i_cmd.exec && set_ok) begin
            al_we = 1'b1;
            al_wa = vi_a;
            al_wd = r_al;
        end else if (i_cmd.vtx_dec && rm) begin
            al_we = 1'b1;
        end
        if (i_cmd.nb_rd) begin
            al_ra = r_ea;
        end else if (i_cmd.vtx_rd) begin
            al_ra = idx_v;
        end else begin
            al_ra = vi_a;
        end
    end

    // Count store port selection.
    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = idx_v;
        cnt_wd = '0;
        if (i_cmd.cnt_clr) begin
            cnt_we = 1'b1;
        end else if (i_cmd.bump_a && do_a) begin
            cnt_we = 1'b1;
            cnt_wa = r_ea;
            cnt_wd = r_cnt_a + 1'b1;
        end else if (i_cmd.bump_b && do_b) begin
            cnt_we = 1'b1;
            cnt_wa = r_eb;
            cnt_wd = r_cnt_b + 1'b1;
        end
        cnt_ra = i_cmd.nb_rd ? r_ea : idx_v;
    end

    // Vertex alive store.
    always_ff @(posedge i_clk) begin
        if (al_we) begin
            m_alive[al_wa] <= al_wd;
        end
        if (i_cmd.nb_rd || i_cmd.vtx_rd || i_cmd.exec) begin
            r_al_a <= m_alive[al_ra];
        end
        if (i_cmd.nb_rd) begin
            r_al_b <= m_alive[r_eb];
        end
    end

    // Neighbour count store.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.nb_rd || i_cmd.vtx_rd) begin
            r_cnt_a <= m_cnt[cnt_ra];
        end
        if (i_cmd.nb_rd) begin
            r_cnt_b <= m_cnt[r_eb];
        end
    end

    // Removed-this-pass store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_dec) begin
            m_rmn[idx_v] <= rm;
        end
        if (i_cmd.mark_rd) begin
            r_rm_a <= m_rmn[r_ea];
            r_rm_b <= m_rmn[r_eb];
        end
    end

    // Edge endpoint store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && add_ok) begin
            m_ep_a[fill_a] <= vi_a;
            m_ep_b[fill_a] <= ni_a;
        end
        if (i_cmd.edge_rd) begin
            r_ea <= m_ep_a[idx_e];
            r_eb <= m_ep_b[idx_e];
        end
    end

    // Edge alive store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && add_ok) begin
            m_ealive[fill_a] <= r_al;
        end else if (i_cmd.mark_wr && in_range && (r_rm_a || r_rm_b)) begin
            m_ealive[idx_e] <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_rde <= m_ealive[ei_a];
        end
    end

    // Sweep index, edge fill and run counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_fill    <= '0;
            r_passes  <= '0;
            r_removed <= '0;
            r_reduced <= 1'b0;
        end else begin
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.exec && add_ok) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.exec && (r_op == mdvp_pkg::OP_CLR_EDGES)) begin
                r_fill <= '0;
            end
            if (i_cmd.run_start) begin
                r_passes  <= '0;
                r_removed <= '0;
            end else if (i_cmd.pass_end) begin
                r_passes <= r_passes + 1'b1;
            end else if (i_cmd.vtx_dec && rm) begin
                r_removed <= r_removed + 1'b1;
            end
            if (i_cmd.run_start || i_cmd.pass_start) begin
                r_reduced <= 1'b0;
            end else if (i_cmd.vtx_dec && rm) begin
                r_reduced <= 1'b1;
            end
        end
    end

    // Status register of the item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= exec_status;
        end
    end

    // Output register: loaded by the controller, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status     <= r_status;
            o_alive_out  <= (r_status == mdvp_pkg::ST_OK) &&
                            (((r_op == mdvp_pkg::OP_RD_VTX) && r_al_a) ||
                             ((r_op == mdvp_pkg::OP_RD_EDGE) && r_rde));
            o_last_pass_reduced <= (r_op == mdvp_pkg::OP_RUN) && r_reduced;
            o_passes_used   <= (r_op == mdvp_pkg::OP_RUN) ? r_passes : '0;
            o_removed_total <= (r_op == mdvp_pkg::OP_RUN) ? r_removed : '0;
            o_edge_total    <= 14'(r_fill);
        end
    end

    assign o_valid = r_ovalid;

    // Status to the controller.
    assign o_stat.idx_lt_nv   = r_idx < IW'(nv);
    assign o_stat.idx_lt_fill = r_idx < IW'(r_fill);
    assign o_stat.idx_last_v  = r_idx == IW'(mdvp_pkg::MAX_VERTICES - 1);
    assign o_stat.more_passes = r_reduced && (r_passes < r_maxp);
    assign o_stat.op_run      = r_op == mdvp_pkg::OP_RUN;
    assign o_stat.out_free    = !r_ovalid || i_ready;

    // The edge fill never passes the store size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(mdvp_pkg::MAX_EDGES))
        else $error("edge fill beyond store size");

    // A run never removes more vertices than the vertex store holds.
    a_removed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_removed <= 11'(mdvp_pkg::MAX_VERTICES))
        else $error("removed count beyond vertex store");

    // Every removal is added to the run's removed count.
    a_remove_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.vtx_dec && rm) |=> (r_removed == $past(r_removed) + 11'd1))
        else $error("removal not counted");

endmodule

// ===== rtl/min_degree_vertex_peeling.sv =====
// Top level of the minimum-degree vertex peeling block.
//
// Items arrive on a valid/ready input channel (operation, vertex, neighbour,
// edge slot, alive mark) and each one yields exactly one result on a
// valid/ready output channel. Configuration registers are written through a
// plain write port (write enable, index, data); the user must write them
// only while the block is idle, and the block itself does not enforce it.
// A load or read item passes the execute and finish steps before its result
// is loaded into the output register; the block takes no new item before it
// is through with the last one. The input reopens even while that result
// waits, and the block then holds in its final step until the output
// register is free. A run walks the stores once per pass; the edge walk
// reads the single-port edge store and updates the count store by
// read-modify-write. No input transfer is taken during a run.
// After reset a clearing sweep sets every vertex alive mark to zero, one
// entry per cycle, with the input closed; configuration writes are taken
// throughout. When the receiver stalls, the result stays in the output
// register.
module min_degree_vertex_peeling (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [9:0]  i_vertex_index,
    input  logic [9:0]  i_neighbor_index,
    input  logic [12:0] i_edge_index,
    input  logic        i_alive_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_alive_out,
    output logic        o_last_pass_reduced,
    output logic [15:0] o_passes_used,
    output logic [10:0] o_removed_total,
    output logic [13:0] o_edge_total
);

    mdvp_pkg::t_dp_cmd  cmd;
    mdvp_pkg::t_dp_stat stat;

    // Sequencer.
    mdvp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Stores and arithmetic.
    mdvp_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_operation         (i_operation),
        .i_vertex_index      (i_vertex_index),
        .i_neighbor_index    (i_neighbor_index),
        .i_edge_index        (i_edge_index),
        .i_alive_in          (i_alive_in),
        .i_ready             (i_ready),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_alive_out         (o_alive_out),
        .o_last_pass_reduced (o_last_pass_reduced),
        .o_passes_used       (o_passes_used),
        .o_removed_total     (o_removed_total),
        .o_edge_total        (o_edge_total)
    );

endmodule
